### hw/rtl/clgp_pkg.sv
`timescale 1ns / 1ps

package clgp_pkg;

    // default number width of a parsed gain
    localparam int CLGP_VALUE_WIDTH = 32;

    localparam int CLGP_NUM_CMDS = 4;
    localparam int CLGP_NUM_VALUES = 3;

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_END   = 8'h00;

    typedef enum logic [2:0] {
        CMD_UNKNOWN = 3'd0,
        CMD_SHOW    = 3'd1,
        CMD_SET_ONE = 3'd2,
        CMD_SET_TWO = 3'd3,
        CMD_GREET   = 3'd4
    } t_cmd;

    // command text, in table order: "PID", "PID1,", "PID2,", "Hello"
    function automatic logic [7:0] cmd_char(input logic [1:0] c, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (c)
            2'd0: begin
                unique case (pos)
                    3'd0:    ch = 8'h50;
                    3'd1:    ch = 8'h49;
                    3'd2:    ch = 8'h44;
                    default: ch = 8'h00;
                endcase
            end
            2'd1, 2'd2: begin
                unique case (pos)
                    3'd0:    ch = 8'h50;
                    3'd1:    ch = 8'h49;
                    3'd2:    ch = 8'h44;
                    3'd3:    ch = (c == 2'd1) ? 8'h31 : 8'h32;
                    3'd4:    ch = 8'h2c;
                    default: ch = 8'h00;
                endcase
            end
            default: begin
                unique case (pos)
                    3'd0:    ch = 8'h48;
                    3'd1:    ch = 8'h65;
                    3'd2:    ch = 8'h6c;
                    3'd3:    ch = 8'h6c;
                    3'd4:    ch = 8'h6f;
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] cmd_len(input logic [1:0] c);
        return (c == 2'd0) ? 3'd3 : 3'd5;
    endfunction

    // prefix commands carry numbers after them
    function automatic logic cmd_args(input logic [1:0] c);
        return (c == 2'd1) || (c == 2'd2);
    endfunction

endpackage

### hw/rtl/command_line_gain_parser.sv
`timescale 1ns / 1ps

// a zero byte is registered in the input register, then the parse stage loads the
// result register, which holds its result word until it is taken
// throughput: one byte per cycle, except while a line end waits for an untaken result word
// reset: synchronous active-low; clears line state, gains and valid flags
// a line end waits in the input register while a result word is still untaken
module command_line_gain_parser #(
    parameter int VALUE_WIDTH = clgp_pkg::CLGP_VALUE_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_line_byte,
    output logic                o_valid,
    input  logic                i_ready,
    output clgp_pkg::t_cmd      o_command_code,
    output logic signed [31:0]  o_motor1_p,
    output logic signed [31:0]  o_motor1_i,
    output logic signed [31:0]  o_motor1_d,
    output logic signed [31:0]  o_motor2_p,
    output logic signed [31:0]  o_motor2_i,
    output logic signed [31:0]  o_motor2_d
);
    import clgp_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int MW = VW - 1;       // magnitude bits
    localparam int PW = VW + 3;       // room for acc * 10 + digit
    localparam logic [PW-1:0] LIMIT_W = {4'b0000, {MW{1'b1}}};

    // input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;

    // per-line state
    logic [2:0]       r_pos, n_pos;
    logic [3:0]       r_alive, n_alive;
    t_cmd             r_matched, n_matched;
    logic             r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [MW-1:0]    r_acc, n_acc;
    logic [1:0]       r_vt, n_vt;
    logic signed [VW-1:0] r_parsed [CLGP_NUM_VALUES];
    logic signed [VW-1:0] n_parsed [CLGP_NUM_VALUES];

    // stored gains, motor one then motor two
    logic signed [VW-1:0] r_gain [6];
    logic signed [VW-1:0] n_gain [6];

    // result register
    logic             r_out_valid, n_out_valid;
    t_cmd             r_out_code, n_out_code;

    logic             advance;
    logic             fire;
    logic             line_end;
    logic [7:0]       b;
    logic             b_digit;
    logic [3:0]       digit;
    logic [PW-1:0]    prod;
    logic [VW-1:0]    cur_value;
    logic             do_skip;
    logic             found;
    logic [1:0]       vt_inc;

    // the parse stage stalls only on a line end with the result word still held
    assign advance = !(r_in_byte == CHAR_END && r_out_valid && !i_ready);
    assign o_ready = !r_in_valid || advance;
    assign fire = r_in_valid && advance;

    assign b = r_in_byte;
    assign line_end = (b == CHAR_END);
    assign b_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign digit = 4'(b - CHAR_ZERO);
    // acc * 10 + digit as shift-add; saturation is the test against the limit
    assign prod = ({3'b000, r_acc, 1'b0} << 2) + {3'b000, r_acc, 1'b0}
                  + PW'(digit);
    // signed value of the number being finished
    assign cur_value = r_neg ? (VW'(0) - {1'b0, r_acc}) : {1'b0, r_acc};
    assign vt_inc = r_vt + 2'd1;

    always_comb begin
        n_pos       = r_pos;
        n_alive     = r_alive;
        n_matched   = r_matched;
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_vt        = r_vt;
        n_parsed    = r_parsed;
        n_gain      = r_gain;
        n_out_code  = r_out_code;
        n_out_valid = r_out_valid && !i_ready;
        do_skip     = 1'b0;
        found       = 1'b0;

        if (fire) begin
            if (r_matched == CMD_UNKNOWN && r_alive != 4'd0) begin
                // command match, first hit in table order wins
                for (int c = 0; c < CLGP_NUM_CMDS; c++) begin
                    if (r_alive[c] && !found) begin
                        if (r_pos < cmd_len(2'(c))) begin
                            if (b == cmd_char(2'(c), r_pos)) begin
                                if (cmd_args(2'(c)) && r_pos == cmd_len(2'(c)) - 3'd1) begin
                                    found     = 1'b1;
                                    n_matched = t_cmd'(3'(c + 1));
                                end
                            end else begin
                                n_alive[c] = 1'b0;
                            end
                        end else if (b == CHAR_END || b == CHAR_CR) begin
                            found     = 1'b1;
                            n_matched = t_cmd'(3'(c + 1));
                        end else begin
                            n_alive[c] = 1'b0;
                        end
                    end
                end
                if (!found && r_pos != 3'd7) begin
                    n_pos = r_pos + 3'd1;
                end
            end else if ((r_matched == CMD_SET_ONE || r_matched == CMD_SET_TWO)
                         && !line_end && r_vt != 2'd3) begin
                if (r_phase) begin
                    if (b_digit) begin
                        n_acc = (prod > LIMIT_W) ? {MW{1'b1}} : prod[MW-1:0];
                    end else begin
                        // number ends; the byte is looked at again
                        n_parsed[r_vt] = cur_value;
                        n_vt    = vt_inc;
                        n_phase = 1'b0;
                        n_neg   = 1'b0;
                        n_acc   = '0;
                        do_skip = (vt_inc != 2'd3);
                    end
                end else begin
                    do_skip = 1'b1;
                end
                if (do_skip) begin
                    if (b_digit) begin
                        n_phase = 1'b1;
                        n_acc   = MW'(digit);
                    end else if (b == CHAR_MINUS) begin
                        n_phase = 1'b1;
                        n_neg   = 1'b1;
                    end else if (b == CHAR_PLUS) begin
                        n_phase = 1'b1;
                    end
                end
            end

            if (line_end) begin
                // a number still open at line end is taken as well
                if (r_vt != 2'd3 && r_phase) begin
                    n_parsed[r_vt] = cur_value;
                end
                for (int k = 0; k < CLGP_NUM_VALUES; k++) begin
                    if (n_matched == CMD_SET_ONE) begin
                        n_gain[k] = n_parsed[k];
                    end else if (n_matched == CMD_SET_TWO) begin
                        n_gain[3 + k] = n_parsed[k];
                    end
                end
                n_out_code  = n_matched;
                n_out_valid = 1'b1;
                // back to the start of a line
                n_pos     = 3'd0;
                n_alive   = 4'hf;
                n_matched = CMD_UNKNOWN;
                n_phase   = 1'b0;
                n_neg     = 1'b0;
                n_acc     = '0;
                n_vt      = 2'd0;
                for (int k = 0; k < CLGP_NUM_VALUES; k++) begin
                    n_parsed[k] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_pos       <= 3'd0;
            r_alive     <= 4'hf;
            r_matched   <= CMD_UNKNOWN;
            r_phase     <= 1'b0;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_vt        <= 2'd0;
            r_out_valid <= 1'b0;
            r_out_code  <= CMD_UNKNOWN;
            for (int k = 0; k < CLGP_NUM_VALUES; k++) begin
                r_parsed[k] <= '0;
            end
            for (int k = 0; k < 6; k++) begin
                r_gain[k] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            r_pos       <= n_pos;
            r_alive     <= n_alive;
            r_matched   <= n_matched;
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_acc       <= n_acc;
            r_vt        <= n_vt;
            r_parsed    <= n_parsed;
            r_gain      <= n_gain;
            r_out_valid <= n_out_valid;
            r_out_code  <= n_out_code;
        end
    end

    // input byte register, payload only
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_line_byte;
        end
    end

    // gains change only at a line end, which waits for the result word to go,
    // so they can drive the result ports directly
    assign o_valid        = r_out_valid;
    assign o_command_code = r_out_code;
    assign o_motor1_p     = 32'(r_gain[0]);
    assign o_motor1_i     = 32'(r_gain[1]);
    assign o_motor1_d     = 32'(r_gain[2]);
    assign o_motor2_p     = 32'(r_gain[3]);
    assign o_motor2_i     = 32'(r_gain[4]);
    assign o_motor2_d     = 32'(r_gain[5]);

`ifndef SYNTHESIS
    // a finished line leaves the parser at the start of a fresh line
    a_line_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && line_end) |=> (r_pos == 3'd0 && r_alive == 4'hf &&
                                r_vt == 2'd0 && !r_phase && r_matched == CMD_UNKNOWN))
        else $error("line state not cleared after line end");

    // numbers are parsed only under a set command
    a_phase_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_matched == CMD_SET_ONE || r_matched == CMD_SET_TWO))
        else $error("number phase without a set command");

    // a held result word is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out_code) &&
                                       $stable(r_gain[0]) && $stable(r_gain[3])))
        else $error("result word changed while stalled");
`endif

endmodule

### tb/gain_report_checker.sv
`timescale 1ns / 1ps

// watches both channels, tracks the parser state and checks every result word
module gain_report_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic [7:0]         i_line_byte,
    input  logic               o_valid,
    input  logic               i_ready,
    input  clgp_pkg::t_cmd     o_command_code,
    input  logic signed [31:0] o_motor1_p,
    input  logic signed [31:0] o_motor1_i,
    input  logic signed [31:0] o_motor1_d,
    input  logic signed [31:0] o_motor2_p,
    input  logic signed [31:0] o_motor2_i,
    input  logic signed [31:0] o_motor2_d,
    output int                 o_mismatch_count,
    output int                 o_pending_reports
);
    import clgp_pkg::*;

    localparam logic [63:0] GAIN_LIMIT = 64'h7fff_ffff;

    // command text left aligned, table order from index 0
    localparam logic [3:0][39:0] COMMAND_TEXT = {"Hello", "PID2,", "PID1,", {"PID", 16'h0}};

    typedef struct packed {
        t_cmd              code;
        logic [5:0][31:0]  gains;
    } t_gain_report;

    t_gain_report expected_reports [$];

    string field_label [7] = '{"command_code", "motor1_p", "motor1_i", "motor1_d",
                               "motor2_p", "motor2_i", "motor2_d"};

    int               scan_pos;
    logic [3:0]       alive_cmds;
    t_cmd             line_cmd;
    logic             in_number;
    logic             number_neg;
    logic [63:0]      number_acc;
    int               numbers_done;
    logic [2:0][31:0] line_values;
    logic [5:0][31:0] stored_gains;
    int               mismatch_total = 0;

    assign o_mismatch_count = mismatch_total;

    task automatic clear_line();
        scan_pos     = 0;
        alive_cmds   = 4'hf;
        line_cmd     = CMD_UNKNOWN;
        in_number    = 1'b0;
        number_neg   = 1'b0;
        number_acc   = '0;
        numbers_done = 0;
        line_values  = '0;
    endtask

    task automatic close_number();
        logic [63:0] v;
        v = number_neg ? (64'd0 - number_acc) : number_acc;
        if (numbers_done < 3) line_values[numbers_done] = v[31:0];
        numbers_done++;
        in_number  = 1'b0;
        number_neg = 1'b0;
        number_acc = '0;
    endtask

    // skipping phase: digit or sign opens a number, anything else is passed over
    task automatic open_number(input logic [7:0] b);
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            in_number  = 1'b1;
            number_acc = 64'(b - CHAR_ZERO);
        end else if (b == CHAR_MINUS) begin
            in_number  = 1'b1;
            number_neg = 1'b1;
        end else if (b == CHAR_PLUS) begin
            in_number = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_gain_report     want;
        logic [6:0][31:0] want_f;
        logic [6:0][31:0] got_f;
        logic [63:0]      digit;
        logic             hit;
        int               c;
        int               k;
        int               len;
        int               base;
        if (!i_rst_n) begin
            clear_line();
            stored_gains = '0;
            expected_reports.delete();
        end else begin
            if (i_valid && o_ready) begin
                if (line_cmd == CMD_UNKNOWN && alive_cmds != 4'h0) begin
                    // match against the table, first hit wins
                    hit = 1'b0;
                    for (c = 0; c < CLGP_NUM_CMDS && !hit; c++) begin
                        len = (c == 0) ? 3 : 5;
                        if (alive_cmds[c]) begin
                            if (scan_pos < len) begin
                                if (i_line_byte == COMMAND_TEXT[c][39 - 8 * scan_pos -: 8]) begin
                                    if ((c == 1 || c == 2) && scan_pos == len - 1) begin
                                        line_cmd = t_cmd'(c + 1);
                                        hit      = 1'b1;
                                    end
                                end else begin
                                    alive_cmds[c] = 1'b0;
                                end
                            end else if (i_line_byte == CHAR_END || i_line_byte == CHAR_CR) begin
                                line_cmd = t_cmd'(c + 1);
                                hit      = 1'b1;
                            end else begin
                                alive_cmds[c] = 1'b0;
                            end
                        end
                    end
                    if (!hit && scan_pos < 7) scan_pos++;
                end else if ((line_cmd == CMD_SET_ONE || line_cmd == CMD_SET_TWO) &&
                             i_line_byte != CHAR_END && numbers_done < 3) begin
                    if (!in_number) begin
                        open_number(i_line_byte);
                    end else if (i_line_byte >= CHAR_ZERO && i_line_byte <= CHAR_NINE) begin
                        digit = 64'(i_line_byte - CHAR_ZERO);
                        if (number_acc > (GAIN_LIMIT - digit) / 10)
                            number_acc = GAIN_LIMIT;
                        else
                            number_acc = number_acc * 10 + digit;
                    end else begin
                        // the byte that ends a number gets a second look
                        close_number();
                        if (numbers_done < 3) open_number(i_line_byte);
                    end
                end

                if (i_line_byte == CHAR_END) begin
                    if (line_cmd == CMD_SET_ONE || line_cmd == CMD_SET_TWO) begin
                        if (numbers_done < 3 && in_number) close_number();
                        base = (line_cmd == CMD_SET_ONE) ? 0 : 3;
                        for (k = 0; k < 3; k++) stored_gains[base + k] = line_values[k];
                    end
                    want.code  = line_cmd;
                    want.gains = stored_gains;
                    expected_reports.push_back(want);
                    clear_line();
                end
            end

            if (o_valid && i_ready) begin
                if (expected_reports.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("unexpected result word, code %0d", o_command_code);
                end else begin
                    want = expected_reports.pop_front();
                    want_f[0] = 32'(want.code);
                    for (k = 0; k < 6; k++) want_f[k + 1] = want.gains[k];
                    got_f[0] = 32'(o_command_code);
                    got_f[1] = o_motor1_p;
                    got_f[2] = o_motor1_i;
                    got_f[3] = o_motor1_d;
                    got_f[4] = o_motor2_p;
                    got_f[5] = o_motor2_i;
                    got_f[6] = o_motor2_d;
                    for (k = 0; k < 7; k++) begin
                        if (want_f[k] !== got_f[k]) begin
                            mismatch_total++;
                            if (mismatch_total <= 10)
                                $display("%s mismatch: expected %0d, got %0d", field_label[k],
                                         $signed(want_f[k]), $signed(got_f[k]));
                        end
                    end
                end
            end
        end
        o_pending_reports <= expected_reports.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

// stimulus and verdict for the command line gain parser; all checking lives in
// the checker instance next to the block
module testbench;
    import clgp_pkg::*;

    // block inputs, known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_line_byte = 8'h00;
    logic        i_ready     = 1'b0;

    logic               o_ready;
    logic               o_valid;
    t_cmd               o_command_code;
    logic signed [31:0] o_motor1_p;
    logic signed [31:0] o_motor1_i;
    logic signed [31:0] o_motor1_d;
    logic signed [31:0] o_motor2_p;
    logic signed [31:0] o_motor2_i;
    logic signed [31:0] o_motor2_d;

    int mismatch_count;
    int pending_reports;

    // every line of the run, zero byte included, in send order
    logic [7:0] line_bytes [$];

    // shared between sender and receiver
    logic quiet        = 1'b0;   // no idling on either side
    logic hold_request = 1'b0;   // asks the receiver for its one long hold-off
    logic hold_done    = 1'b0;
    int   stall_left   = 0;

    command_line_gain_parser DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_line_byte    (i_line_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_command_code (o_command_code),
        .o_motor1_p     (o_motor1_p),
        .o_motor1_i     (o_motor1_i),
        .o_motor1_d     (o_motor1_d),
        .o_motor2_p     (o_motor2_p),
        .o_motor2_i     (o_motor2_i),
        .o_motor2_d     (o_motor2_d)
    );

    gain_report_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_line_byte       (i_line_byte),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_command_code    (o_command_code),
        .o_motor1_p        (o_motor1_p),
        .o_motor1_i        (o_motor1_i),
        .o_motor1_d        (o_motor1_d),
        .o_motor2_p        (o_motor2_p),
        .o_motor2_i        (o_motor2_i),
        .o_motor2_d        (o_motor2_d),
        .o_mismatch_count  (mismatch_count),
        .o_pending_reports (pending_reports)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // single reset at the start
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("** command_line_gain_parser: FAILED **");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b);
        line_bytes.push_back(b);
    endtask

    task automatic push_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) line_bytes.push_back(s[k]);
    endtask

    // one random line; mostly well-formed commands with random content,
    // the rest near misses and plain noise
    task automatic make_random_line();
        int    kind;
        int    k;
        int    n;
        int    cut;
        string pick;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            // gain setting line with zero to five numbers
            if ($urandom_range(0, 1)) push_text("PID1,");
            else push_text("PID2,");
            repeat ($urandom_range(0, 5)) begin
                case ($urandom_range(0, 3))
                    0:       push_byte(",");
                    1:       push_byte(" ");
                    2:       push_byte(8'($urandom_range(1, 255)));
                    default: ;
                endcase
                case ($urandom_range(0, 3))
                    0:       push_byte(CHAR_MINUS);
                    1:       push_byte(CHAR_PLUS);
                    default: ;
                endcase
                // mostly short numbers, now and then long enough to saturate
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 6);
                for (k = 0; k < n; k++) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 4) == 0) push_byte(8'($urandom_range(1, 255)));
        end else if (kind < 70) begin
            // show or greeting, usually closed by cr, with junk behind it
            if ($urandom_range(0, 1)) push_text("PID");
            else push_text("Hello");
            if ($urandom_range(0, 3) != 0) push_byte(CHAR_CR);
            repeat ($urandom_range(0, 6)) push_byte(8'($urandom_range(1, 255)));
        end else if (kind < 85) begin
            // near miss: a command cut short with one random byte in place, then up to eight more
            case ($urandom_range(0, 3))
                0:       pick = "PID";
                1:       pick = "PID1,";
                2:       pick = "PID2,";
                default: pick = "Hello";
            endcase
            cut = $urandom_range(0, pick.len() - 1);
            for (k = 0; k < cut; k++) push_byte(pick[k]);
            push_byte(8'($urandom_range(1, 255)));
            repeat ($urandom_range(0, 8)) push_byte(8'($urandom_range(1, 255)));
        end else begin
            repeat ($urandom_range(0, 15)) push_byte(8'($urandom_range(1, 255)));
        end
        push_byte(CHAR_END);
    endtask

    // receiver: random stall bursts plus one long hold-off on request, so the block
    // backs up and drops o_ready
    always @(posedge i_clk) begin
        if (hold_request && !hold_done) begin
            i_ready    <= 1'b0;
            stall_left <= 400;
            hold_done  <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // sender and verdict
    initial begin : sender
        int idx;
        int directed_total;
        int drain;
        bit calm;
        bit quiet_now;
        calm = 1'b0;

        // directed lines
        push_text("PID"); push_byte(CHAR_END);                        // show, all gains zero
        push_text("PID"); push_byte(CHAR_CR); push_byte(CHAR_END);
        push_text("PID"); push_byte(CHAR_CR); push_text("xyz");       // junk after cr ignored
        push_byte(8'hff); push_byte(CHAR_END);
        push_text("Hello"); push_byte(CHAR_END);
        push_text("Hello"); push_byte(CHAR_CR); push_byte(8'h80);
        push_byte(8'h7f); push_text("PID1,5"); push_byte(CHAR_END);
        push_text("PIDX"); push_byte(CHAR_END);                       // unknown, trailing byte
        push_text("Hell"); push_byte(CHAR_END);                       // unknown, cut short
        push_byte(CHAR_END);                                          // empty line
        push_text("PID1,1000,-2000,+3"); push_byte(CHAR_END);
        push_text("PID2,2147483647,-99999999999,5"); push_byte(CHAR_END); // negative saturates
        push_text("PID1,-2147483648 +0"); push_byte(CHAR_END);
        push_text("PID"); push_byte(CHAR_END);
        push_text("PID1,"); push_byte(CHAR_END);                      // all numbers missing
        push_text("PID2,-"); push_byte(CHAR_END);                     // sign with no digits
        push_text("PID1,+,-7 9"); push_byte(CHAR_END);
        push_text("PID2,1,2,3,4,5"); push_byte(CHAR_END);             // extra numbers dropped
        push_text("PID1,12a34-5"); push_byte(CHAR_END);               // terminator looked at again
        push_text("PID1"); push_byte(CHAR_END);                       // prefix without comma
        push_text("HelloX"); push_byte(CHAR_END);
        push_text("PIDPIDPID1,"); push_byte(CHAR_END);                // long unknown line
        push_text("Hello"); push_byte(CHAR_END);
        directed_total = line_bytes.size();

        // random lines fill the run up to about 850 bytes in all
        while (line_bytes.size() < 850) make_random_line();

        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        for (idx = 0; idx < line_bytes.size(); idx++) begin
            // calm stretches come and go; the tail of the run has no idling at all
            if ($urandom_range(0, 63) == 0) calm = !calm;
            quiet_now = calm || (idx >= line_bytes.size() - 120);
            quiet <= quiet_now;
            if (idx == directed_total + 60) hold_request <= 1'b1;
            if (!quiet_now && $urandom_range(0, 3) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            i_valid     <= 1'b1;
            i_line_byte <= line_bytes[idx];
            // word goes at the first edge that sees ready
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
        end
        i_valid <= 1'b0;

        // let the checker take in the last line end, then drain the results
        repeat (2) @(posedge i_clk);
        drain = 0;
        while (pending_reports != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        // margin for any stray word
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0 && pending_reports == 0)
            $display("** command_line_gain_parser: PASSED **");
        else
            $display("** command_line_gain_parser: FAILED **");
        $finish;
    end

endmodule
